FILE: sv/gsa_pkg.sv
`timescale 1ns / 1ps

package gsa_pkg;

  localparam int unsigned SLOTS    = 256;
  localparam int unsigned GEN_BITS = 16;
  localparam int unsigned IDX_W    = $clog2(SLOTS);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned FLAG_W   = 3;

  // flag bit positions
  localparam int unsigned FL_ALIVE = 0;
  localparam int unsigned FL_VALUE = 1;
  localparam int unsigned FL_TEXT  = 2;

  typedef enum logic [1:0] {
    MODE_ALLOC   = 2'd0,
    MODE_RELEASE = 2'd1,
    MODE_LOOKUP  = 2'd2,
    MODE_FLAGS   = 2'd3
  } mode_e;

  typedef struct packed {
    mode_e                     mode;
    logic [IDX_W-1:0]          slot_index;
    logic [GEN_BITS-1:0]       slot_generation;
    logic                      with_value;
    logic signed [VAL_W-1:0]   value_in;
    logic                      with_text;
    logic [FLAG_W-1:0]         flag_mask;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]          handle_index;
    logic [GEN_BITS-1:0]       handle_generation;
    logic                      ok;
    logic                      full_res;
    logic                      value_present;
    logic signed [VAL_W-1:0]   value_out;
    logic                      text_present;
  } rsp_t;

endpackage

FILE: sv/gsa_req_if.sv
`timescale 1ns / 1ps

interface gsa_req_if import gsa_pkg::*; ();
  logic valid;
  logic ready;
  req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/gsa_rsp_if.sv
`timescale 1ns / 1ps

interface gsa_rsp_if import gsa_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: sv/generational_slot_allocator_unit.sv
`timescale 1ns / 1ps

// Generational slot allocator. Requests (allocate, release, lookup, flag test)
// arrive on req_i, one result per request leaves on rsp_o. Slot state
// (generation, flags, value) lives in one synchronous RAM and the LIFO free
// list in a second one, both with a registered read port. The request is
// registered at the transfer, its slot read into the read register, and the
// result register loads in the execute step; an allocate that reuses a
// released slot first pops the free list in a pop step and then reads the
// slot. The order of steps is set by the serial read of the free-list RAM
// and the slot RAM. A new request is taken while the previous result still
// waits in the output register; the block stalls in its execute step only if
// that register is occupied and not drained in the same cycle. The RAMs need
// no clearing: only slots below the used count and free-list entries below
// the free count ever affect a result.
module generational_slot_allocator_unit import gsa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gsa_req_if.sink   req_i,
  gsa_rsp_if.source rsp_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_EXEC
  } state_e;

  typedef enum logic [1:0] {
    AK_FRESH,
    AK_REUSE,
    AK_FULL
  } alloc_kind_e;

  typedef struct packed {
    logic [GEN_BITS-1:0]     gen;
    logic [FLAG_W-1:0]       flags;
    logic signed [VAL_W-1:0] value;
  } slot_t;

  // slot RAM and free-list RAM
  slot_t            slot_mem [SLOTS];
  logic [IDX_W-1:0] stack_mem [SLOTS];

  state_e           state_q;
  alloc_kind_e      kind_q;
  req_t             req_q;
  logic [IDX_W-1:0] slot_q;
  logic             in_range_q;
  logic [CNT_W-1:0] free_count_q;
  logic [CNT_W-1:0] slots_used_q;
  logic             rsp_valid_q;
  rsp_t             rsp_q;

  slot_t            slot_rd_q;
  logic [IDX_W-1:0] stack_rd_q;

  logic [IDX_W-1:0] slot_raddr;
  logic [IDX_W-1:0] stack_raddr;
  logic             slot_we;
  slot_t            slot_wdata;
  logic             stack_we;
  logic             req_fire;
  logic             exec_fire;
  logic             hit;
  logic             push_ok;
  rsp_t             rsp_d;

  assign req_i.ready   = (state_q == ST_IDLE);
  assign req_fire      = req_i.valid && req_i.ready;
  assign exec_fire     = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);
  assign rsp_o.valid   = rsp_valid_q;
  assign rsp_o.payload = rsp_q;

  // top of the free list sits one below the count
  assign stack_raddr = IDX_W'(free_count_q - CNT_W'(1));

  // slot address follows the step: request index, popped slot, then held
  always_comb begin
    unique case (state_q)
      ST_IDLE: slot_raddr = req_i.payload.slot_index;
      ST_POP:  slot_raddr = stack_rd_q;
      ST_EXEC: slot_raddr = slot_q;
      default: slot_raddr = slot_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_rd_q  <= slot_mem[slot_raddr];
    stack_rd_q <= stack_mem[stack_raddr];
    if (slot_we) begin
      slot_mem[slot_q] <= slot_wdata;
    end
    if (stack_we) begin
      stack_mem[free_count_q[IDX_W-1:0]] <= slot_q;
    end
  end

  // live handle check for release and lookup
  assign hit = in_range_q && slot_rd_q.flags[FL_ALIVE] &&
               (slot_rd_q.gen == req_q.slot_generation);
  assign push_ok = hit && (free_count_q < CNT_W'(SLOTS));

  always_comb begin
    rsp_d      = '0;
    slot_we    = 1'b0;
    slot_wdata = slot_rd_q;
    stack_we   = 1'b0;
    unique case (req_q.mode)
      MODE_ALLOC: begin
        slot_wdata.flags[FL_ALIVE] = 1'b1;
        slot_wdata.flags[FL_VALUE] = req_q.with_value;
        slot_wdata.flags[FL_TEXT]  = req_q.with_text;
        slot_wdata.value = req_q.with_value ? req_q.value_in : '0;
        // reused slots bump the generation, fresh ones start at zero
        slot_wdata.gen = (kind_q == AK_REUSE) ? slot_rd_q.gen + GEN_BITS'(1) : '0;
        if (kind_q == AK_FULL) begin
          rsp_d.full_res = 1'b1;
        end else begin
          slot_we                 = exec_fire;
          rsp_d.handle_index      = slot_q;
          rsp_d.handle_generation = slot_wdata.gen;
          rsp_d.ok                = 1'b1;
        end
      end
      MODE_RELEASE: begin
        slot_wdata.flags[FL_ALIVE] = 1'b0;
        slot_we  = exec_fire && push_ok;
        stack_we = exec_fire && push_ok;
      end
      MODE_LOOKUP: begin
        if (hit) begin
          rsp_d.ok            = 1'b1;
          rsp_d.value_present = slot_rd_q.flags[FL_VALUE];
          rsp_d.value_out     = slot_rd_q.flags[FL_VALUE] ? slot_rd_q.value : '0;
          rsp_d.text_present  = slot_rd_q.flags[FL_TEXT];
        end
      end
      MODE_FLAGS: begin
        rsp_d.ok = in_range_q && ((slot_rd_q.flags & req_q.flag_mask) == req_q.flag_mask);
      end
      default: begin
        rsp_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      kind_q       <= AK_FULL;
      req_q        <= '0;
      slot_q       <= '0;
      free_count_q <= '0;
      slots_used_q <= '0;
      rsp_valid_q  <= 1'b0;
      rsp_q        <= '0;
      in_range_q   <= 1'b0;
    end else begin
      // a new result wins over the drain of the old one
      if (exec_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (req_fire) begin
            req_q      <= req_i.payload;
            in_range_q <= {1'b0, req_i.payload.slot_index} < slots_used_q;
            if (req_i.payload.mode == MODE_ALLOC && free_count_q != '0) begin
              slot_q       <= req_i.payload.slot_index;
              free_count_q <= free_count_q - CNT_W'(1);
              kind_q       <= AK_REUSE;
              state_q      <= ST_POP;
            end else begin
              state_q <= ST_EXEC;
              if (req_i.payload.mode == MODE_ALLOC && slots_used_q < CNT_W'(SLOTS)) begin
                slot_q       <= slots_used_q[IDX_W-1:0];
                slots_used_q <= slots_used_q + CNT_W'(1);
                kind_q       <= AK_FRESH;
              end else begin
                // kind only matters for an allocate, which is then refused
                slot_q <= req_i.payload.slot_index;
                kind_q <= AK_FULL;
              end
            end
          end
        end
        ST_POP: begin
          slot_q  <= stack_rd_q;
          state_q <= ST_EXEC;
        end
        ST_EXEC: begin
          if (exec_fire) begin
            rsp_q   <= rsp_d;
            state_q <= ST_IDLE;
            if (stack_we) begin
              free_count_q <= free_count_q + CNT_W'(1);
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: tb/sv/generational_slot_allocator_unit_test.sv
`timescale 1ns / 1ps

module generational_slot_allocator_unit_test;
  import gsa_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 3_000_000;
  localparam int unsigned IDLE_PCT     = 20;
  localparam int unsigned SHOW_MAX     = 10;
  localparam int unsigned REUSE_ROUNDS = 32;

  logic clk_i = 1'b0;
  logic rst_ni;

  gsa_req_if req ();
  gsa_rsp_if rsp ();

  generational_slot_allocator_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Shadow copy of the slot map, advanced once per accepted request.
  logic [GEN_BITS-1:0] gen_tab   [SLOTS];
  logic [FLAG_W-1:0]   flag_tab  [SLOTS];
  logic [VAL_W-1:0]    val_tab   [SLOTS];
  logic [IDX_W-1:0]    free_list [SLOTS];
  int unsigned         free_cnt;
  int unsigned         used_cnt;
  bit                  took_effect;

  rsp_t awaited_rsp [$];

  bit          calm;
  int unsigned errors;
  int unsigned cycle_count;
  int unsigned n_checked, n_alloc, n_full, n_freed, n_hits, n_wraps;

  // Apply one request to the shadow map and return the result it must produce.
  function automatic rsp_t slot_map_apply(input req_t r);
    rsp_t             res;
    logic [IDX_W-1:0] s;
    logic [FLAG_W-1:0] f;
    bit               got;
    bit               live;
    res = '0;
    got = 1'b0;
    took_effect = 1'b1;
    live = (r.slot_index < used_cnt) && flag_tab[r.slot_index][FL_ALIVE] &&
           (gen_tab[r.slot_index] == r.slot_generation);
    case (r.mode)
      MODE_ALLOC: begin
        if (free_cnt > 0) begin
          // LIFO reuse: newest released slot first, generation bumped
          free_cnt--;
          s = free_list[free_cnt];
          gen_tab[s] = gen_tab[s] + 1'b1;
          if (gen_tab[s] == '0) n_wraps++;
          got = 1'b1;
        end else if (used_cnt < SLOTS) begin
          s = IDX_W'(used_cnt);
          used_cnt++;
          gen_tab[s] = '0;
          got = 1'b1;
        end
        if (got) begin
          f = '0;
          f[FL_ALIVE] = 1'b1;
          f[FL_VALUE] = r.with_value;
          f[FL_TEXT]  = r.with_text;
          flag_tab[s] = f;
          val_tab[s] = r.with_value ? r.value_in : '0;
          res.handle_index = s;
          res.handle_generation = gen_tab[s];
          res.ok = 1'b1;
          n_alloc++;
        end else begin
          res.full_res = 1'b1;
          n_full++;
        end
      end
      MODE_RELEASE: begin
        if (live && free_cnt < SLOTS) begin
          flag_tab[r.slot_index][FL_ALIVE] = 1'b0;
          free_list[free_cnt] = r.slot_index;
          free_cnt++;
          n_freed++;
        end else begin
          took_effect = 1'b0;
        end
      end
      MODE_LOOKUP: begin
        if (live) begin
          res.ok = 1'b1;
          res.value_present = flag_tab[r.slot_index][FL_VALUE];
          res.value_out = res.value_present ? val_tab[r.slot_index] : '0;
          res.text_present = flag_tab[r.slot_index][FL_TEXT];
          n_hits++;
        end
      end
      default: begin
        // flag test ignores the generation; mask 0 passes on any used slot
        if (r.slot_index < used_cnt && (flag_tab[r.slot_index] & r.flag_mask) == r.flag_mask)
          res.ok = 1'b1;
      end
    endcase
    return res;
  endfunction

  function automatic req_t make_req(input mode_e m, input int unsigned idx,
                                    input logic [GEN_BITS-1:0] gen, input bit wv,
                                    input logic [VAL_W-1:0] val, input bit wt,
                                    input logic [FLAG_W-1:0] mask);
    req_t r;
    r.mode = m;
    r.slot_index = IDX_W'(idx);
    r.slot_generation = gen;
    r.with_value = wv;
    r.value_in = val;
    r.with_text = wt;
    r.flag_mask = mask;
    return r;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(19))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // Fields the mode does not use still get random contents.
  function automatic req_t rand_fill(input mode_e m, input int unsigned idx,
                                     input logic [GEN_BITS-1:0] gen);
    return make_req(m, idx, gen, 1'($urandom_range(1)), pick_value(),
                    1'($urandom_range(1)), FLAG_W'($urandom_range(7)));
  endfunction

  // One request transfer; the expected result is queued at the accepting edge.
  task automatic send_request(input req_t item);
    rsp_t expected;
    @(negedge clk_i);
    if (!calm && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk_i);
    end
    req.payload <= item;
    req.valid   <= 1'b1;
    do @(posedge clk_i); while (!req.ready);
    expected = slot_map_apply(item);
    awaited_rsp.insert(awaited_rsp.size(), expected);
  endtask

  task automatic wait_until_drained();
    @(negedge clk_i);
    req.valid <= 1'b0;
    while (awaited_rsp.size() != 0) @(posedge clk_i);
  endtask

  // Receiver side: random back-pressure unless a calm stretch is running.
  always @(negedge clk_i)
    rsp.ready <= calm || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk_i) cycle_count++;

  // Result checker: every transfer on the result side against the oldest expectation.
  always @(posedge clk_i) begin
    rsp_t got;
    rsp_t want;
    bit   bad;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got = rsp.payload;
      if (awaited_rsp.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display("[%0t] result with nothing outstanding: idx %0d gen %0d ok %b", $realtime,
                   got.handle_index, got.handle_generation, got.ok);
      end else begin
        want = awaited_rsp.pop_front();
        n_checked++;
        bad = (got.handle_index !== want.handle_index) ||
              (got.handle_generation !== want.handle_generation) ||
              (got.ok !== want.ok) || (got.full_res !== want.full_res) ||
              (got.value_present !== want.value_present) ||
              (got.value_out !== want.value_out) ||
              (got.text_present !== want.text_present);
        if (bad) begin
          errors++;
          if (errors <= SHOW_MAX) begin
            $display("[%0t] result %0d mismatch", $realtime, n_checked);
            $display("  expected idx %0d gen %0d ok %b full %b vp %b val %0d tp %b",
                     want.handle_index, want.handle_generation, want.ok, want.full_res,
                     want.value_present, want.value_out, want.text_present);
            $display("  actual   idx %0d gen %0d ok %b full %b vp %b val %0d tp %b",
                     got.handle_index, got.handle_generation, got.ok, got.full_res,
                     got.value_present, got.value_out, got.text_present);
          end
        end
      end
    end
  end

  // Directed corners: empty table, value extremes, absent value, stale handles,
  // double release, flag masks including 0, LIFO reuse with generation bump.
  task automatic test_directed();
    send_request(make_req(MODE_LOOKUP, 0, '0, 1'b1, '1, 1'b1, 3'd7));
    send_request(make_req(MODE_FLAGS, 255, '1, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_RELEASE, 0, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_ALLOC, 0, '0, 1'b1, 32'h7fff_ffff, 1'b1, 3'd0));
    send_request(make_req(MODE_ALLOC, 0, '0, 1'b1, 32'h8000_0000, 1'b0, 3'd0));
    send_request(make_req(MODE_ALLOC, 0, '0, 1'b0, 32'hdead_beef, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 0, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 1, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 2, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 0, '1, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_FLAGS, 0, '0, 1'b0, '0, 1'b0, 3'd7));
    send_request(make_req(MODE_FLAGS, 1, '0, 1'b0, '0, 1'b0, 3'd7));
    send_request(make_req(MODE_FLAGS, 1, '0, 1'b0, '0, 1'b0, 3'd3));
    send_request(make_req(MODE_FLAGS, 2, '1, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_RELEASE, 1, '1, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_RELEASE, 1, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_RELEASE, 1, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 1, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_FLAGS, 1, '0, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_FLAGS, 1, '0, 1'b0, '0, 1'b0, 3'd1));
    send_request(make_req(MODE_ALLOC, 0, '0, 1'b1, '1, 1'b1, 3'd0));
    send_request(make_req(MODE_LOOKUP, 1, 16'd1, 1'b0, '0, 1'b0, 3'd0));
    send_request(make_req(MODE_LOOKUP, 255, '1, 1'b0, '0, 1'b0, 3'd0));
    wait_until_drained();
  endtask

  // Fill every slot, bounce off the full table, then free some and refill.
  task automatic test_fill_to_full();
    int unsigned idx;
    while (used_cnt < SLOTS || free_cnt > 0)
      send_request(rand_fill(MODE_ALLOC, $urandom_range(255), 16'($urandom)));
    repeat (3) send_request(rand_fill(MODE_ALLOC, $urandom_range(255), 16'($urandom)));
    repeat (40) begin
      do idx = $urandom_range(SLOTS - 1); while (!flag_tab[idx][FL_ALIVE]);
      send_request(rand_fill(MODE_RELEASE, idx, gen_tab[idx]));
    end
    repeat (42) send_request(rand_fill(MODE_ALLOC, $urandom_range(255), 16'($urandom)));
    wait_until_drained();
  endtask

  // Cycle one slot through release and reuse so its generation climbs, with
  // lookups on the fresh and the stale handle. No idling on either side.
  task automatic test_slot_reuse();
    int unsigned         idx;
    logic [GEN_BITS-1:0] old_gen;
    calm = 1'b1;
    do idx = $urandom_range(used_cnt - 1); while (!flag_tab[idx][FL_ALIVE]);
    repeat (REUSE_ROUNDS) begin
      old_gen = gen_tab[idx];
      send_request(rand_fill(MODE_RELEASE, idx, old_gen));
      send_request(rand_fill(MODE_ALLOC, $urandom_range(255), 16'($urandom)));
      send_request(rand_fill(MODE_LOOKUP, idx, gen_tab[idx]));
      send_request(rand_fill(MODE_LOOKUP, idx, old_gen));
    end
    wait_until_drained();
    calm = 1'b0;
  endtask

  // Mostly well-formed traffic on stored handles, a share of stale
  // generations, and some fully random noise. Ignored releases do not count.
  task automatic test_random_phase(input int unsigned alloc_pct, input int unsigned target);
    int unsigned effective;
    int unsigned pick;
    int unsigned rest;
    int unsigned idx;
    logic [GEN_BITS-1:0] gen;
    req_t item;
    effective = 0;
    rest = 100 - alloc_pct;
    while (effective < target) begin
      pick = $urandom_range(99);
      idx = (used_cnt > 0) ? $urandom_range(used_cnt - 1) : $urandom_range(SLOTS - 1);
      gen = gen_tab[idx];
      if ($urandom_range(99) < 12) gen = gen ^ (GEN_BITS'(1) << $urandom_range(GEN_BITS - 1));
      if (pick < alloc_pct)
        item = rand_fill(MODE_ALLOC, $urandom_range(255), 16'($urandom));
      else if (pick < alloc_pct + rest * 35 / 100)
        item = rand_fill(MODE_RELEASE, idx, gen);
      else if (pick < alloc_pct + rest * 65 / 100)
        item = rand_fill(MODE_LOOKUP, idx, gen);
      else if (pick < alloc_pct + rest * 85 / 100)
        item = rand_fill(MODE_FLAGS, idx, gen);
      else
        item = rand_fill(mode_e'($urandom_range(3)), $urandom_range(255), 16'($urandom));
      send_request(item);
      if (took_effect) effective++;
    end
    // hold the sender until the block has answered everything
    wait_until_drained();
  endtask

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_ni      = 1'b0;
    req.valid   = 1'b0;
    req.payload = '0;
    rsp.ready   = 1'b0;
    calm        = 1'b0;
    free_cnt    = 0;
    used_cnt    = 0;
    foreach (gen_tab[i]) begin
      gen_tab[i]   = '0;
      flag_tab[i]  = '0;
      val_tab[i]   = '0;
      free_list[i] = '0;
    end
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_fill_to_full();
    test_slot_reuse();
    test_random_phase(50, 250);
    test_random_phase(20, 250);
    test_random_phase(70, 250);
    test_random_phase(30, 250);

    repeat (8) @(posedge clk_i);
    $display("Checked %0d results: %0d allocations, %0d refused on a full table, %0d releases,",
             n_checked, n_alloc, n_full, n_freed);
    $display("%0d live lookups, %0d generation wraps, over %0d cycles",
             n_hits, n_wraps, cycle_count);
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
